// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Types, register indexes and constants shared by the triangle shader.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int CoordW = 7;
  localparam int IdxW   = 3;
  localparam int EdgeW  = 17;
  localparam int MagW   = 16;
  localparam int RemW   = 24;
  localparam int ColW   = 8;

  localparam int DefImageWidth  = 128;
  localparam int DefImageHeight = 128;

  localparam logic [IdxW-1:0] REG_A_X = 3'd0;
  localparam logic [IdxW-1:0] REG_A_Y = 3'd1;
  localparam logic [IdxW-1:0] REG_B_X = 3'd2;
  localparam logic [IdxW-1:0] REG_B_Y = 3'd3;
  localparam logic [IdxW-1:0] REG_C_X = 3'd4;
  localparam logic [IdxW-1:0] REG_C_Y = 3'd5;

  localparam logic [CoordW-1:0] RST_A_X = 7'd61;
  localparam logic [CoordW-1:0] RST_A_Y = 7'd10;
  localparam logic [CoordW-1:0] RST_B_X = 7'd100;
  localparam logic [CoordW-1:0] RST_B_Y = 7'd100;
  localparam logic [CoordW-1:0] RST_C_X = 7'd25;
  localparam logic [CoordW-1:0] RST_C_Y = 7'd90;

  localparam logic [ColW-1:0] BG_RED   = 8'd255;
  localparam logic [ColW-1:0] BG_GREEN = 8'd255;
  localparam logic [ColW-1:0] BG_BLUE  = 8'd192;

  typedef struct packed {
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
  } bts_vtx_t;

  typedef struct packed {
    logic                      valid;
    logic                      covered;
    logic [2:0][MagW-1:0]      den;
    logic [2:0][RemW-1:0]      rem;
    logic [2:0][ColW-1:0]      quo;
  } bts_div_t;

endpackage

// File: rtl/bts_pix_if.sv
// ----------------------------------------------------------------------------
// bts_pix_if
// Pixel coordinate channel.
// ----------------------------------------------------------------------------
interface bts_pix_if;
  logic       valid;
  logic       ready;
  logic [6:0] pixel_x;
  logic [6:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/bts_shade_if.sv
// ----------------------------------------------------------------------------
// bts_shade_if
// Shaded pixel result channel.
// ----------------------------------------------------------------------------
interface bts_shade_if;
  logic       valid;
  logic       ready;
  logic       covered;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output covered, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input covered, input red, input green, input blue,
                output ready);
endinterface

// File: rtl/bts_cfg_if.sv
// ----------------------------------------------------------------------------
// bts_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface bts_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/barycentric_triangle_shader_core.sv
// ----------------------------------------------------------------------------
// barycentric_triangle_shader_core
// Barycentric coverage and colour for one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  dir  payload                     beat when
//  pix      in   pixel_x, pixel_y            valid && ready
//  shade    out  covered, red, green, blue   valid && ready
//  cfg      in   index, data                 valid (ready held high)
//
// Seven register stages: three for edges and test, four for the divider.
// One pixel per clock while the output is not stalled.
// A stalled output freezes every stage together; pix.ready follows it.
// Synchronous reset clears valid bits and loads the default triangle.
// ----------------------------------------------------------------------------
module barycentric_triangle_shader_core #(
  parameter int IMAGE_WIDTH  = bts_pkg::DefImageWidth,
  parameter int IMAGE_HEIGHT = bts_pkg::DefImageHeight
) (
  input  logic        clk,
  input  logic        rst,
  bts_pix_if.sink     pix,
  bts_shade_if.source shade,
  bts_cfg_if.sink     cfg
);
  import bts_pkg::*;

  bts_vtx_t vtx;
  logic     en;
  bts_div_t s0, s1, s2, s3, s4;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx <= '{RST_A_X, RST_A_Y, RST_B_X, RST_B_Y, RST_C_X, RST_C_Y};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_A_X: vtx.ax <= cfg.data;
        REG_A_Y: vtx.ay <= cfg.data;
        REG_B_X: vtx.bx <= cfg.data;
        REG_B_Y: vtx.by <= cfg.data;
        REG_C_X: vtx.cx <= cfg.data;
        REG_C_Y: vtx.cy <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en        = !s4.valid || shade.ready;
  assign pix.ready = en;

  bts_edge #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_edge (
    .clk(clk), .rst(rst), .en(en), .in_valid(pix.valid),
    .px(pix.pixel_x), .py(pix.pixel_y), .vtx(vtx), .d_out(s0)
  );

  bts_div_stage #(.BIT_HI(7)) u_div0 (.clk(clk), .rst(rst), .en(en), .d_in(s0), .d_out(s1));
  bts_div_stage #(.BIT_HI(5)) u_div1 (.clk(clk), .rst(rst), .en(en), .d_in(s1), .d_out(s2));
  bts_div_stage #(.BIT_HI(3)) u_div2 (.clk(clk), .rst(rst), .en(en), .d_in(s2), .d_out(s3));
  bts_div_stage #(.BIT_HI(1)) u_div3 (.clk(clk), .rst(rst), .en(en), .d_in(s3), .d_out(s4));

  assign shade.valid   = s4.valid;
  assign shade.covered = s4.covered;
  assign shade.red     = s4.covered ? s4.quo[0] : BG_RED;
  assign shade.green   = s4.covered ? s4.quo[1] : BG_GREEN;
  assign shade.blue    = s4.covered ? s4.quo[2] : BG_BLUE;

endmodule

// File: rtl/bts_edge.sv
// ----------------------------------------------------------------------------
// bts_edge
// Edge functions, coverage test and scaled numerators (three stages).
// ----------------------------------------------------------------------------
module bts_edge #(
  parameter int IMAGE_WIDTH  = bts_pkg::DefImageWidth,
  parameter int IMAGE_HEIGHT = bts_pkg::DefImageHeight
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [6:0]          px,
  input  logic [6:0]          py,
  input  bts_pkg::bts_vtx_t   vtx,
  output bts_pkg::bts_div_t   d_out
);
  import bts_pkg::*;

  logic [5:0][CoordW-1:0] qx, qy, p1x, p1y, p2x, p2y;
  logic signed [5:0][15:0] pa_next, pb_next;

  logic                    v1, out1;
  logic signed [5:0][15:0] pa, pb;
  logic                    v2, out2;
  logic signed [5:0][EdgeW-1:0] e;
  logic signed [5:0][EdgeW-1:0] e_next;
  logic                    outside;

  logic                       ok;
  logic [2:0][MagW-1:0]       nmag, dmag;
  logic [2:0][RemW-1:0]       scaled;

  // edges: 0 na, 1 da, 2 nb, 3 db, 4 nc, 5 dc  (even = at pixel)
  always_comb begin
    qx  = {vtx.cx, vtx.cx, vtx.bx, vtx.bx, vtx.ax, px};
    qy  = {vtx.cy, vtx.cy, vtx.by, vtx.by, vtx.ay, py};
    qx[4] = px; qy[4] = py; qx[2] = px; qy[2] = py;
    qx[5] = vtx.cx; qy[5] = vtx.cy; qx[3] = vtx.bx; qy[3] = vtx.by;
    qx[1] = vtx.ax; qy[1] = vtx.ay;
    p1x = {vtx.bx, vtx.bx, vtx.ax, vtx.ax, vtx.bx, vtx.bx};
    p1y = {vtx.by, vtx.by, vtx.ay, vtx.ay, vtx.by, vtx.by};
    p2x = {vtx.ax, vtx.ax, vtx.cx, vtx.cx, vtx.cx, vtx.cx};
    p2y = {vtx.ay, vtx.ay, vtx.cy, vtx.cy, vtx.cy, vtx.cy};
    for (int i = 0; i < 6; i++) begin
      pa_next[i] = $signed({1'b0, qx[i]} - {1'b0, p1x[i]}) *
                   $signed({1'b0, p2y[i]} - {1'b0, p1y[i]});
      pb_next[i] = $signed({1'b0, qy[i]} - {1'b0, p1y[i]}) *
                   $signed({1'b0, p2x[i]} - {1'b0, p1x[i]});
    end
    for (int i = 0; i < 6; i++) begin
      e_next[i] = EdgeW'($signed(pb[i])) - EdgeW'($signed(pa[i]));
    end
  end

  assign outside = (32'(px) >= IMAGE_WIDTH) || (32'(py) >= IMAGE_HEIGHT);

  always_comb begin
    ok = !out2;
    for (int k = 0; k < 3; k++) begin
      nmag[k] = e[2*k][EdgeW-1]   ? MagW'(-e[2*k])   : MagW'(e[2*k]);
      dmag[k] = e[2*k+1][EdgeW-1] ? MagW'(-e[2*k+1]) : MagW'(e[2*k+1]);
      scaled[k] = {nmag[k], 8'd0} - RemW'(nmag[k]);
      if (e[2*k+1] == '0) ok = 1'b0;
      if (e[2*k] != '0 && (e[2*k][EdgeW-1] != e[2*k+1][EdgeW-1])) ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      d_out.valid <= v2;
    end
    if (en) begin
      pa   <= pa_next;
      pb   <= pb_next;
      out1 <= outside;
      e    <= e_next;
      out2 <= out1;
      d_out.covered <= ok;
      d_out.den     <= dmag;
      d_out.rem     <= scaled;
      d_out.quo     <= '0;
    end
  end

endmodule

// File: rtl/bts_div_stage.sv
// ----------------------------------------------------------------------------
// bts_div_stage
// Two restoring quotient bits for each of the three colour channels.
// ----------------------------------------------------------------------------
module bts_div_stage #(
  parameter int BIT_HI = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  bts_pkg::bts_div_t d_in,
  output bts_pkg::bts_div_t d_out
);
  import bts_pkg::*;

  bts_div_t d_next;
  logic [RemW-1:0] trial;

  always_comb begin
    d_next = d_in;
    for (int k = 0; k < 3; k++) begin
      for (int b = BIT_HI; b > BIT_HI - 2; b--) begin
        trial = RemW'(d_next.den[k]) << b;
        if (d_next.rem[k] >= trial) begin
          d_next.rem[k]    = d_next.rem[k] - trial;
          d_next.quo[k][b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_next.valid;
    end
    if (en) begin
      d_out.covered <= d_next.covered;
      d_out.den     <= d_next.den;
      d_out.rem     <= d_next.rem;
      d_out.quo     <= d_next.quo;
    end
  end

endmodule
